>>> hw/rtl/obn_pkg.sv
// Shared types and constants for the orthonormal basis pipeline.
`timescale 1ns / 1ps
package obn_pkg;

	localparam logic [1:0] OP_V = 2'd1;
	localparam logic [1:0] OP_W = 2'd2;

	localparam logic [14:0] EPS_RESET  = 15'd16;
	localparam logic [29:0] EPS2_RESET = 30'd256;

	// Normalizer: squares, sum, one quotient bit per stage, one root bit per stage, output.
	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 16;
	localparam int NORM_LAT   = DIV_STEPS + SQRT_STEPS + 3;
	localparam int PIPE_LAST  = 2 * NORM_LAT + 4;

	typedef logic [2:0][15:0] vec3_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
		logic signed [15:0] in_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] u_x;
		logic signed [15:0] u_y;
		logic signed [15:0] u_z;
		logic signed [15:0] v_x;
		logic signed [15:0] v_y;
		logic signed [15:0] v_z;
		logic signed [15:0] w_x;
		logic signed [15:0] w_y;
		logic signed [15:0] w_z;
		logic               degenerate;
	} out_t;

endpackage

>>> hw/rtl/orthonormal_basis_from_axis.sv
// Top level: builds an orthonormal basis from one given axis vector.
// Usage:
//   src channel takes one word: op (0 = u, 1 = v, 2 = w, 3 as u) and a
//   3-vector at any common scale. dst channel gives one word per input:
//   nine Q1.14 components and a degenerate flag (zero input, all zero).
//   cfg_we/cfg_wdata write epsilon; write it only while the block is idle.
// Pipeline: two passes through the normalizer, each a 31-stage
//   quotient pipeline and a 16-stage square root pipeline.
// Throughput: one word per cycle, sustained while the pipeline is not frozen.
// Stall: while dst_stall holds a waiting result, the pipeline keeps moving
//   until its last stage is full; then the whole pipeline freezes and
//   src_stall rises (combinationally from dst_stall) until dst takes it.
// Reset: clears all valid bits and the output valid; epsilon returns to
//   16. No clearing pass; the block takes words right after reset.
`timescale 1ns / 1ps
module orthonormal_basis_from_axis (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_stall,
	input  obn_pkg::in_t   src_data,
	output logic           dst_valid,
	input  logic           dst_stall,
	output obn_pkg::out_t  dst_data,
	input  logic           cfg_we,
	input  logic [14:0]    cfg_wdata
);
	import obn_pkg::*;

	function automatic logic [15:0] round_q14(input logic signed [32:0] d);
		logic signed [32:0] e;
		logic signed [18:0] r;
		e = d + 33'sd8192;
		r = 19'(e >>> 14);
		if (r > 19'sd16384)
			return 16'sd16384;
		if (r < -19'sd16384)
			return -16'sd16384;
		return r[15:0];
	endfunction

	logic [14:0] eps_q;
	logic [29:0] eps2_q;
	logic        en;
	logic [PIPE_LAST:0] vld_s;

	assign en        = !dst_valid || !dst_stall || !vld_s[PIPE_LAST];
	assign src_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q  <= EPS_RESET;
			eps2_q <= EPS2_RESET;
		end else begin
			if (cfg_we)
				eps_q <= cfg_wdata;
			eps2_q <= 30'(eps_q) * 30'(eps_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[PIPE_LAST-1:0], src_valid};
	end

	// stage 1: input word
	logic [1:0] op_s1;
	logic       deg_s1;
	vec3_t      g_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= src_data.op;
			deg_s1 <= (src_data.in_x == '0) && (src_data.in_y == '0) && (src_data.in_z == '0);
			g_s1   <= {src_data.in_z, src_data.in_y, src_data.in_x};
		end
	end

	// first normalize: the given axis
	vec3_t a_n;
	logic [1:0] op_sa  [1:NORM_LAT];
	logic       deg_sa [1:NORM_LAT];

	obn_norm3 u_norm_a (.clk(clk), .en(en), .vin(g_s1), .vout(a_n));

	always_ff @(posedge clk) begin
		if (en) begin
			op_sa[1]  <= op_s1;
			deg_sa[1] <= deg_s1;
			for (int k = 2; k <= NORM_LAT; k++) begin
				op_sa[k]  <= op_sa[k-1];
				deg_sa[k] <= deg_sa[k-1];
			end
		end
	end

	// stage 2: squares for the rejection test
	vec3_t       a_s2;
	logic [1:0]  op_s2;
	logic        deg_s2;
	logic [28:0] sqy_s2, sqz_s2;
	logic signed [31:0] py, pz;

	assign py = $signed(a_n[1]) * $signed(a_n[1]);
	assign pz = $signed(a_n[2]) * $signed(a_n[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= a_n;
			op_s2  <= op_sa[NORM_LAT];
			deg_s2 <= deg_sa[NORM_LAT];
			sqy_s2 <= py[28:0];
			sqz_s2 <= pz[28:0];
		end
	end

	// stage 3: pick the helper axis (x, or y when the x cross is too short)
	vec3_t      a_s3, t_s3;
	logic [1:0] op_s3;
	logic       deg_s3;
	logic       use_y;

	assign use_y = (30'(sqy_s2) + 30'(sqz_s2)) < eps2_q;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= a_s2;
			op_s3  <= op_s2;
			deg_s3 <= deg_s2;
			if (use_y)
				t_s3 <= {a_s2[0], 16'd0, 16'(-a_s2[2])};
			else
				t_s3 <= {16'(-a_s2[1]), a_s2[2], 16'd0};
		end
	end

	// second normalize: the helper cross product
	vec3_t s_n;
	vec3_t      a_sb   [1:NORM_LAT];
	logic [1:0] op_sb  [1:NORM_LAT];
	logic       deg_sb [1:NORM_LAT];

	obn_norm3 u_norm_b (.clk(clk), .en(en), .vin(t_s3), .vout(s_n));

	always_ff @(posedge clk) begin
		if (en) begin
			a_sb[1]   <= a_s3;
			op_sb[1]  <= op_s3;
			deg_sb[1] <= deg_s3;
			for (int k = 2; k <= NORM_LAT; k++) begin
				a_sb[k]   <= a_sb[k-1];
				op_sb[k]  <= op_sb[k-1];
				deg_sb[k] <= deg_sb[k-1];
			end
		end
	end

	// stage 4: cross product partial products, P x Q
	vec3_t p_v, q_v;
	vec3_t a_s4, s_s4;
	logic [1:0] op_s4;
	logic       deg_s4;
	logic signed [31:0] m_s4 [6];

	always_comb begin
		if (op_sb[NORM_LAT] == OP_V) begin
			p_v = s_n;
			q_v = a_sb[NORM_LAT];
		end else begin
			p_v = a_sb[NORM_LAT];
			q_v = s_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= a_sb[NORM_LAT];
			s_s4   <= s_n;
			op_s4  <= op_sb[NORM_LAT];
			deg_s4 <= deg_sb[NORM_LAT];
			m_s4[0] <= $signed(p_v[1]) * $signed(q_v[2]);
			m_s4[1] <= $signed(p_v[2]) * $signed(q_v[1]);
			m_s4[2] <= $signed(p_v[2]) * $signed(q_v[0]);
			m_s4[3] <= $signed(p_v[0]) * $signed(q_v[2]);
			m_s4[4] <= $signed(p_v[0]) * $signed(q_v[1]);
			m_s4[5] <= $signed(p_v[1]) * $signed(q_v[0]);
		end
	end

	// stage 5: difference, round, clamp
	vec3_t a_s5, s_s5, c_s5;
	logic [1:0] op_s5;
	logic       deg_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5   <= a_s4;
			s_s5   <= s_s4;
			op_s5  <= op_s4;
			deg_s5 <= deg_s4;
			for (int i = 0; i < 3; i++)
				c_s5[i] <= round_q14(33'(m_s4[2*i]) - 33'(m_s4[2*i+1]));
		end
	end

	// output register
	vec3_t ou, ov, ow;
	out_t  res;

	always_comb begin
		case (op_s5)
			OP_V: begin
				ou = s_s5;
				ov = a_s5;
				ow = c_s5;
			end
			OP_W: begin
				ou = s_s5;
				ov = c_s5;
				ow = a_s5;
			end
			default: begin
				ou = a_s5;
				ov = s_s5;
				ow = c_s5;
			end
		endcase
		res = '0;
		res.degenerate = deg_s5;
		if (!deg_s5) begin
			res.u_x = ou[0];
			res.u_y = ou[1];
			res.u_z = ou[2];
			res.v_x = ov[0];
			res.v_y = ov[1];
			res.v_z = ov[2];
			res.w_x = ow[0];
			res.w_y = ow[1];
			res.w_z = ow[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else begin
			if (dst_valid && !dst_stall)
				dst_valid <= 1'b0;
			if (en && vld_s[PIPE_LAST])
				dst_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s[PIPE_LAST])
			dst_data <= res;
	end

`ifndef SYNTHESIS
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.degenerate |->
			dst_data.u_x == '0 && dst_data.v_y == '0 && dst_data.w_z == '0)
		else $error("degenerate word with nonzero axes");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> dst_valid && dst_stall && vld_s[PIPE_LAST])
		else $error("input stalled without a blocked result");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved while frozen");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[PIPE_LAST] |=> dst_valid)
		else $error("finished word not loaded into output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> $signed(dst_data.w_x) <= 16'sd16384 &&
			$signed(dst_data.w_x) >= -16'sd16384)
		else $error("third axis out of Q1.14 range");
`endif

endmodule

>>> hw/rtl/obn_norm3.sv
// Pipelined 3-vector normalizer to Q1.14 (restoring divide, then digit-by-digit root).
`timescale 1ns / 1ps
module obn_norm3 (
	input  logic          clk,
	input  logic          en,
	input  obn_pkg::vec3_t vin,
	output obn_pkg::vec3_t vout
);
	import obn_pkg::*;

	logic [30:0] c2_s1 [3];
	logic [2:0]  neg_s1;

	logic [31:0] rem_dv [0:DIV_STEPS][3];
	logic [30:0] q_dv   [0:DIV_STEPS][3];
	logic [31:0] s_dv   [0:DIV_STEPS];
	logic        zero_dv[0:DIV_STEPS];
	logic [2:0]  neg_dv [0:DIV_STEPS];

	logic [30:0] sn_sq  [1:SQRT_STEPS][3];
	logic [31:0] sr_sq  [1:SQRT_STEPS][3];
	logic        zero_sq[1:SQRT_STEPS];
	logic [2:0]  neg_sq [1:SQRT_STEPS];

	logic [15:0] mag [3];
	logic [31:0] sq  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vin[i][15] ? 16'(-vin[i]) : vin[i];
			sq[i]  = 32'(mag[i]) * 32'(mag[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c2_s1[i]  <= sq[i][30:0];
				neg_s1[i] <= vin[i][15];
			end
		end
	end

	// sum of squares; the first remainder is the square itself
	always_ff @(posedge clk) begin
		if (en) begin
			s_dv[0]    <= 32'(c2_s1[0]) + 32'(c2_s1[1]) + 32'(c2_s1[2]);
			zero_dv[0] <= (c2_s1[0] == '0) && (c2_s1[1] == '0) && (c2_s1[2] == '0);
			neg_dv[0]  <= neg_s1;
			for (int i = 0; i < 3; i++) begin
				rem_dv[0][i] <= 32'(c2_s1[i]);
				q_dv[0][i]   <= '0;
			end
		end
	end

	// quotient of c*c*2^30 / S, one bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [32:0] t [3];
		logic [2:0]  ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]  = (j == 0) ? {1'b0, rem_dv[j][i]} : {rem_dv[j][i], 1'b0};
				ge[i] = t[i] >= {1'b0, s_dv[j]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_dv[j+1][i] <= ge[i] ? 32'(t[i] - {1'b0, s_dv[j]}) : t[i][31:0];
					q_dv[j+1][i]   <= {q_dv[j][i][29:0], ge[i]};
				end
				s_dv[j+1]    <= s_dv[j];
				zero_dv[j+1] <= zero_dv[j];
				neg_dv[j+1]  <= neg_dv[j];
			end
		end
	end

	// floor square root, one result bit per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [31:0] B = 32'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [30:0] n_in [3];
		logic [31:0] r_in [3];
		logic        z_in;
		logic [2:0]  g_in;
		logic [31:0] rb   [3];
		logic [2:0]  ge;
		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					n_in[i] = q_dv[DIV_STEPS][i];
					r_in[i] = '0;
				end
				z_in = zero_dv[DIV_STEPS];
				g_in = neg_dv[DIV_STEPS];
			end
		end else begin : g_rest
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					n_in[i] = sn_sq[k][i];
					r_in[i] = sr_sq[k][i];
				end
				z_in = zero_sq[k];
				g_in = neg_sq[k];
			end
		end
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rb[i] = r_in[i] + B;
				ge[i] = {1'b0, n_in[i]} >= rb[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					sn_sq[k+1][i] <= ge[i] ? 31'({1'b0, n_in[i]} - rb[i]) : n_in[i];
					sr_sq[k+1][i] <= ge[i] ? (r_in[i] >> 1) + B : r_in[i] >> 1;
				end
				zero_sq[k+1] <= z_in;
				neg_sq[k+1]  <= g_in;
			end
		end
	end

	logic [16:0] rnd [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			rnd[i] = 17'(sr_sq[SQRT_STEPS][i]) + 17'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_sq[SQRT_STEPS])
					vout[i] <= '0;
				else if (neg_sq[SQRT_STEPS][i])
					vout[i] <= 16'(-rnd[i][16:1]);
				else
					vout[i] <= rnd[i][16:1];
			end
		end
	end

endmodule

>>> tb/orthonormal_basis_from_axis_tb.sv
// Self-checking testbench for the orthonormal basis block.
`timescale 1ns / 1ps
module orthonormal_basis_from_axis_tb;
	import obn_pkg::*;

	localparam logic [1:0] OP_U  = 2'd0;
	localparam logic [1:0] OP_X3 = 2'd3;
	localparam int LATENCY = 105;
	localparam int ONE = 16384;

	logic  clk;
	logic  arst_n;
	logic  src_valid;
	logic  src_stall;
	in_t   src_data;
	logic  dst_valid;
	logic  dst_stall;
	out_t  dst_data;
	logic  cfg_we;
	logic  [14:0] cfg_wdata;

	in_t   pending_words[$];
	out_t  basis_expected[$];
	logic  [14:0] eps_model;
	int    errors;
	int    accepted;
	int    checked;
	int    degenerate_seen;
	bit    stim_done;

	orthonormal_basis_from_axis i_dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
		.dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void unit_vec(input longint a[3], output longint r[3]);
		longint unsigned s, q;
		longint mag;
		s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
		for (int i = 0; i < 3; i++) begin
			if (s == 0) begin
				r[i] = 0;
			end else begin
				q = (longint'(a[i]*a[i]) << 30) / s;
				mag = (root_floor(q) + 1) >> 1;
				r[i] = a[i] < 0 ? -mag : mag;
			end
		end
	endfunction

	function automatic longint round_clamp(longint d);
		longint r;
		r = (d + 8192) >>> 14;
		if (r > ONE) r = ONE;
		if (r < -ONE) r = -ONE;
		return r;
	endfunction

	function automatic void cross_round(input longint a[3], input longint b[3],
			output longint r[3]);
		r[0] = round_clamp(a[1]*b[2] - a[2]*b[1]);
		r[1] = round_clamp(a[2]*b[0] - a[0]*b[2]);
		r[2] = round_clamp(a[0]*b[1] - a[1]*b[0]);
	endfunction

	// x-axis cross unless too short, then y-axis cross
	function automatic void perp_axis(input longint a[3], output longint r[3]);
		longint t[3];
		longint unsigned len2, eps2;
		len2 = a[1]*a[1] + a[2]*a[2];
		eps2 = longint'(eps_model) * longint'(eps_model);
		if (len2 < eps2) begin
			t[0] = -a[2]; t[1] = 0; t[2] = a[0];
		end else begin
			t[0] = 0; t[1] = a[2]; t[2] = -a[1];
		end
		unit_vec(t, r);
	endfunction

	function automatic out_t predict_basis(in_t w);
		out_t o;
		longint g[3], a[3], u[3], v[3], x[3];
		o = '0;
		g[0] = w.in_x; g[1] = w.in_y; g[2] = w.in_z;
		if (g[0] == 0 && g[1] == 0 && g[2] == 0) begin
			o.degenerate = 1'b1;
			return o;
		end
		unit_vec(g, a);
		if (w.op == OP_V) begin
			v = a; perp_axis(v, u); cross_round(u, v, x);
		end else if (w.op == OP_W) begin
			x = a; perp_axis(x, u); cross_round(x, u, v);
		end else begin
			u = a; perp_axis(u, v); cross_round(u, v, x);
		end
		o.u_x = 16'(u[0]); o.u_y = 16'(u[1]); o.u_z = 16'(u[2]);
		o.v_x = 16'(v[0]); o.v_y = 16'(v[1]); o.v_z = 16'(v[2]);
		o.w_x = 16'(x[0]); o.w_y = 16'(x[1]); o.w_z = 16'(x[2]);
		return o;
	endfunction

	function automatic in_t make_word(logic [1:0] op, int x, int y, int z);
		in_t w;
		w.op = op; w.in_x = 16'(x); w.in_y = 16'(y); w.in_z = 16'(z);
		return w;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
			2: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	// handshakes seen at the rising edge, used by the falling-edge drivers
	bit src_fire;
	bit dst_fire;

	always @(posedge clk) begin
		src_fire <= arst_n && src_valid && !src_stall;
		dst_fire <= arst_n && dst_valid && !dst_stall;
	end

	// driver: one word per pending entry, random gap before each
	int src_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_data  <= '0;
			src_gap   <= $urandom_range(0, 7);
		end else begin
			if (src_fire)
				void'(pending_words.pop_front());
			if (src_fire || !src_valid) begin
				if (pending_words.size() > 0 && src_gap == 0) begin
					src_valid <= 1'b1;
					src_data  <= pending_words[0];
					src_gap   <= $urandom_range(0, 7);
				end else begin
					src_valid <= 1'b0;
					if (src_gap > 0)
						src_gap <= src_gap - 1;
				end
			end
		end
	end

	// dst side stall pattern: a fresh random wait after each word
	int dst_hold;
	int dst_wait;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall <= 1'b1;
			dst_hold  <= 0;
		end else if (dst_fire) begin
			dst_wait   = $urandom_range(0, 7);
			dst_hold  <= dst_wait;
			dst_stall <= dst_wait != 0;
		end else if (dst_hold > 0) begin
			dst_hold  <= dst_hold - 1;
			dst_stall <= dst_hold > 1;
		end else begin
			dst_stall <= 1'b0;
		end
	end

	// predictor and checker, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && src_valid && !src_stall) begin
			basis_expected.push_back(predict_basis(src_data));
			accepted++;
		end
		if (arst_n && dst_valid && !dst_stall) begin
			out_t e;
			if (basis_expected.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = basis_expected.pop_front();
				checked++;
				if (e.degenerate) degenerate_seen++;
				if (dst_data.u_x !== e.u_x) begin $error("u_x exp %0d got %0d", e.u_x, dst_data.u_x); errors++; end
				if (dst_data.u_y !== e.u_y) begin $error("u_y exp %0d got %0d", e.u_y, dst_data.u_y); errors++; end
				if (dst_data.u_z !== e.u_z) begin $error("u_z exp %0d got %0d", e.u_z, dst_data.u_z); errors++; end
				if (dst_data.v_x !== e.v_x) begin $error("v_x exp %0d got %0d", e.v_x, dst_data.v_x); errors++; end
				if (dst_data.v_y !== e.v_y) begin $error("v_y exp %0d got %0d", e.v_y, dst_data.v_y); errors++; end
				if (dst_data.v_z !== e.v_z) begin $error("v_z exp %0d got %0d", e.v_z, dst_data.v_z); errors++; end
				if (dst_data.w_x !== e.w_x) begin $error("w_x exp %0d got %0d", e.w_x, dst_data.w_x); errors++; end
				if (dst_data.w_y !== e.w_y) begin $error("w_y exp %0d got %0d", e.w_y, dst_data.w_y); errors++; end
				if (dst_data.w_z !== e.w_z) begin $error("w_z exp %0d got %0d", e.w_z, dst_data.w_z); errors++; end
				if (dst_data.degenerate !== e.degenerate) begin
					$error("degenerate exp %0d got %0d", e.degenerate, dst_data.degenerate);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_words.size() > 0 || basis_expected.size() > 0) @(posedge clk);
	endtask

	task automatic write_epsilon(logic [14:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		eps_model = value;
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) begin
			logic [1:0] op;
			int x, y, z;
			op = $urandom_range(0, 7) == 0 ? OP_X3 : 2'($urandom_range(0, 2));
			x = rand_comp(); y = rand_comp(); z = rand_comp();
			// near x-axis vectors exercise the fallback axis
			if ($urandom_range(0, 3) == 0) begin
				y = $signed(16'($urandom_range(0, 64))) - 32;
				z = $signed(16'($urandom_range(0, 64))) - 32;
			end
			pending_words.push_back(make_word(op, x, y, z));
		end
	endtask

	initial begin
		logic [14:0] eps_plan[6];
		errors = 0; accepted = 0; checked = 0; degenerate_seen = 0;
		stim_done = 0;
		eps_model = EPS_RESET;
		cfg_we = 1'b0; cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, each op, zero vector, axis-aligned vectors
		pending_words.push_back(make_word(OP_U, 0, 0, 0));
		pending_words.push_back(make_word(OP_V, 0, 0, 0));
		pending_words.push_back(make_word(OP_U, 1, 0, 0));
		pending_words.push_back(make_word(OP_V, 0, 1, 0));
		pending_words.push_back(make_word(OP_W, 0, 0, 1));
		pending_words.push_back(make_word(OP_X3, 3, 4, 5));
		pending_words.push_back(make_word(OP_U, 32767, 32767, 32767));
		pending_words.push_back(make_word(OP_V, -32768, -32768, -32768));
		pending_words.push_back(make_word(OP_W, -32768, 32767, -1));
		pending_words.push_back(make_word(OP_U, -32768, 0, 0));
		pending_words.push_back(make_word(OP_W, 32767, 1, -1));
		pending_words.push_back(make_word(OP_V, 100, 0, -1));
		pending_words.push_back(make_word(OP_X3, -1, -1, -1));
		pending_words.push_back(make_word(OP_W, 0, -32768, 32767));
		queue_random(300);
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);

		// epsilon sweep, extremes included; values above one always pick the y-axis fallback
		eps_plan = '{15'd0, 15'd16384, 15'd32767, 15'd1, 15'd2000, 15'($urandom)};
		foreach (eps_plan[k]) begin
			write_epsilon(eps_plan[k]);
			pending_words.push_back(make_word(OP_U, 1000, 3, -2));
			pending_words.push_back(make_word(OP_W, -7, 0, 0));
			queue_random(250);
			wait_drained();
			repeat (LATENCY + 10) @(posedge clk);
		end
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		$display("Checked %0d basis words (%0d degenerate) over several epsilon settings.",
			checked, degenerate_seen);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("Timeout after %0d accepted words", accepted);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
